>>> sv/jsme_pkg.sv
// ----------------------------------------------------------------------------
// jsme_pkg: shared constants and types of the scan command encoder
// MPSSE opcodes, request limits and the item descriptor passed to the emitter.
// ----------------------------------------------------------------------------
package jsme_pkg;

  // MPSSE opcodes
  localparam logic [7:0] CmdTms      = 8'h4b;
  localparam logic [7:0] CmdTmsRd    = 8'h6b;
  localparam logic [7:0] CmdBytes    = 8'h19;
  localparam logic [7:0] CmdBytesRd  = 8'h39;
  localparam logic [7:0] CmdBits     = 8'h1b;
  localparam logic [7:0] CmdBitsRd   = 8'h3b;

  localparam int unsigned MaxScanBitsDef = 64;

  // prologue limits with and without data, capture length limit
  localparam logic [3:0] TmsMaxData = 4'd11;
  localparam logic [3:0] TmsMaxIdle = 4'd14;
  localparam logic [6:0] ErrLimit   = 7'd56;

  typedef struct packed {
    logic        decode;
    logic        capture;
    logic        has_data;
    logic [3:0]  tms_len;
    logic [14:0] tms_val;
    logic [2:0]  nbytes;
    logic [2:0]  lbb;
    logic        last_bit;
    logic [3:0]  reply_bytes;
    logic        error;
  } item_t;

endpackage

>>> sv/jtag_scan_mpsse_command_encoder_unit.sv
// ----------------------------------------------------------------------------
// jtag_scan_mpsse_command_encoder_unit: JTAG scan request to MPSSE encoder
// Turns scan requests into MPSSE command bytes and realigns captured replies.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one request per beat. With
//   mode_i low the request becomes 3 to 25 command bytes on the output
//   channel (out_valid_o/out_ready_i), one byte per beat, last_byte_o on the
//   final one; a request with no prologue and no data gives no beat at all.
//   With mode_i high one beat carries the realigned reply in decoded_word_o,
//   using the masks left by the most recent capture scan.
//   A request is loaded into the sequencer first, then its first byte into the output register.
//   Throughput: one output byte per cycle while the receiver is ready; the
//   next request is taken in the cycle its last byte is emitted, so the
//   stream has no gaps between items.
//   When the receiver stalls, the output register holds its beat and the
//   sequencer and input side wait behind it.
//   Reset empties the sequencer and clears the repair masks, so a decode
//   before any capture scan passes the word through unchanged.
// ----------------------------------------------------------------------------
module jtag_scan_mpsse_command_encoder_unit #(
  parameter int unsigned MaxScanBits = jsme_pkg::MaxScanBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [3:0]  tms_count_i,
  input  logic [13:0] tms_bits_i,
  input  logic [6:0]  data_count_i,
  input  logic [63:0] data_bits_i,
  input  logic        capture_i,
  input  logic [63:0] reply_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_byte_o,
  output logic [63:0] decoded_word_o,
  output logic [3:0]  reply_bytes_o,
  output logic        error_o
);

  localparam logic [6:0] MaxDc = 7'(MaxScanBits);

  // repair masks of the last capture scan
  logic [2:0]  partial_bits_q;
  logic [63:0] partial_byte_mask_q;
  logic [63:0] last_bit_source_mask_q;
  logic [63:0] top_bit_mask_q;

  logic [6:0]  dc;
  logic        has_data;
  logic [3:0]  tc_lim, tc;
  logic [14:0] tb_mask, tms_val;
  logic [5:0]  n;
  logic [2:0]  nbytes, lbb;
  logic [3:0]  wb;
  logic [2:0]  wb_m1;
  logic [63:0] pbm_new, lbsm_new, tbm_new;
  logic        cap_scan;

  logic        hb;
  logic [2:0]  rsh;
  logic [63:0] top, w_part, w_trim, realigned;

  jsme_pkg::item_t item;
  logic            item_valid;
  logic            in_take;

  always_comb begin
    dc       = (data_count_i > MaxDc) ? MaxDc : data_count_i;
    has_data = dc != 7'd0;
    tc_lim   = has_data ? jsme_pkg::TmsMaxData : jsme_pkg::TmsMaxIdle;
    tc       = (tms_count_i > tc_lim) ? tc_lim : tms_count_i;
    tb_mask  = (15'd1 << tc) - 15'd1;
    tms_val  = ({1'b0, tms_bits_i} & tb_mask) | (has_data ? (15'd1 << tc) : 15'd0);
    n        = 6'(dc - 7'd1);
    nbytes   = n[5:3];
    lbb      = n[2:0];
    wb       = {1'b0, nbytes} + {3'd0, lbb != 3'd0};
    wb_m1    = 3'(wb - 4'd1);
    pbm_new  = (lbb != 3'd0) ? (64'hff << {wb_m1, 3'b000}) : 64'd0;
    // reply byte holding the last bit may fall beyond the word
    lbsm_new = wb[3] ? 64'd0 : (64'h40 << {wb[2:0], 3'b000});
    tbm_new  = 64'd1 << n;
    cap_scan = !mode_i && has_data && capture_i;
  end

  // reply realignment
  always_comb begin
    hb     = (reply_word_i & last_bit_source_mask_q) != 64'd0;
    rsh    = 3'(4'd8 - {1'b0, partial_bits_q});
    top    = partial_byte_mask_q & ((reply_word_i & partial_byte_mask_q) >> rsh);
    w_part = (partial_bits_q != 3'd0) ?
             ((reply_word_i & ~partial_byte_mask_q) | top) : reply_word_i;
    w_trim = w_part & (top_bit_mask_q - 64'd1);
    realigned = hb ? (w_trim | top_bit_mask_q) : w_trim;
  end

  always_comb begin
    item.decode      = mode_i;
    item.capture     = capture_i;
    item.has_data    = has_data;
    item.tms_len     = tc + (has_data ? 4'd3 : 4'd0);
    item.tms_val     = tms_val;
    item.nbytes      = nbytes;
    item.lbb         = lbb;
    item.last_bit    = data_bits_i[n];
    item.reply_bytes = cap_scan ? 4'(wb + 4'd1) : 4'd0;
    item.error       = cap_scan && (dc > jsme_pkg::ErrLimit);
  end

  // empty requests are accepted and dropped
  assign item_valid = in_valid_i && (mode_i || tc != 4'd0 || has_data);
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_bits_q         <= 3'd0;
      partial_byte_mask_q    <= 64'd0;
      last_bit_source_mask_q <= 64'd0;
      top_bit_mask_q         <= 64'd0;
    end else if (in_take && cap_scan) begin
      partial_bits_q         <= lbb;
      partial_byte_mask_q    <= pbm_new;
      last_bit_source_mask_q <= lbsm_new;
      top_bit_mask_q         <= tbm_new;
    end
  end

  jsme_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_ready_o   (in_ready_o),
    .item_i         (item),
    .word_i         (mode_i ? realigned : data_bits_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_byte_o    (last_byte_o),
    .decoded_word_o (decoded_word_o),
    .reply_bytes_o  (reply_bytes_o),
    .error_o        (error_o)
  );

endmodule

>>> sv/jsme_emit.sv
// ----------------------------------------------------------------------------
// jsme_emit: command byte sequencer
// Holds one item and walks its command bytes, or its decoded word, into a
// registered output, one byte per cycle unless the output stalls; a new item
// loads on the cycle its predecessor's last byte leaves.
// ----------------------------------------------------------------------------
module jsme_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  input  jsme_pkg::item_t item_i,
  input  logic [63:0]    word_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           last_byte_o,
  output logic [63:0]    decoded_word_o,
  output logic [3:0]     reply_bytes_o,
  output logic           error_o
);

  typedef enum logic [2:0] {
    PhTms,
    PhHdr,
    PhData,
    PhBits,
    PhTail,
    PhDec
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [2:0]      idx_q, idx_d;
  logic            busy_q;
  jsme_pkg::item_t item_q;
  logic [63:0]     data_q, data_d;

  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic            last_q;
  logic [63:0]     decoded_q;
  logic [3:0]      reply_q;
  logic            err_q;

  logic [7:0]      byte_d;
  logic            fin;
  logic            can_emit;
  logic            take;
  logic            tms_short;
  logic [2:0]      tms_end;
  phase_e          after_tms;

  assign tms_short = item_q.tms_len < 4'd8;
  assign tms_end   = tms_short ? 3'd2 : 3'd5;
  assign after_tms = (item_q.nbytes != 3'd0) ? PhHdr :
                     (item_q.lbb != 3'd0)    ? PhBits : PhTail;

  always_comb begin
    byte_d  = 8'h00;
    fin     = 1'b0;
    phase_d = phase_q;
    idx_d   = idx_q + 3'd1;
    data_d  = data_q;
    unique case (phase_q)
      PhTms: begin
        unique case (idx_q)
          3'd0: byte_d = jsme_pkg::CmdTms;
          3'd1: byte_d = tms_short ? 8'(item_q.tms_len - 4'd1) : 8'd6;
          3'd2: byte_d = tms_short ? item_q.tms_val[7:0] : {1'b0, item_q.tms_val[6:0]};
          3'd3: byte_d = jsme_pkg::CmdTms;
          3'd4: byte_d = 8'(item_q.tms_len - 4'd8);
          3'd5: byte_d = item_q.tms_val[14:7];
          default: byte_d = 8'h00;
        endcase
        if (idx_q == tms_end) begin
          if (item_q.has_data) begin
            phase_d = after_tms;
            idx_d   = 3'd0;
          end else begin
            fin = 1'b1;
          end
        end
      end
      PhHdr: begin
        unique case (idx_q)
          3'd0: byte_d = item_q.capture ? jsme_pkg::CmdBytesRd : jsme_pkg::CmdBytes;
          3'd1: byte_d = {5'd0, item_q.nbytes - 3'd1};
          default: byte_d = 8'h00;
        endcase
        if (idx_q == 3'd2) begin
          phase_d = PhData;
          idx_d   = 3'd0;
        end
      end
      PhData: begin
        byte_d = data_q[7:0];
        data_d = data_q >> 8;
        if (idx_q == item_q.nbytes - 3'd1) begin
          phase_d = (item_q.lbb != 3'd0) ? PhBits : PhTail;
          idx_d   = 3'd0;
        end
      end
      PhBits: begin
        unique case (idx_q)
          3'd0: byte_d = item_q.capture ? jsme_pkg::CmdBitsRd : jsme_pkg::CmdBits;
          3'd1: byte_d = {5'd0, item_q.lbb - 3'd1};
          default: byte_d = data_q[7:0];
        endcase
        if (idx_q == 3'd2) begin
          phase_d = PhTail;
          idx_d   = 3'd0;
        end
      end
      PhTail: begin
        // last data bit goes out with tms high, then back to idle
        unique case (idx_q)
          3'd0: byte_d = item_q.capture ? jsme_pkg::CmdTmsRd : jsme_pkg::CmdTms;
          3'd1: byte_d = 8'd1;
          3'd2: byte_d = {item_q.last_bit, 5'd0, 2'b11};
          3'd3: byte_d = jsme_pkg::CmdTms;
          default: byte_d = 8'h00;
        endcase
        fin = (idx_q == 3'd5);
      end
      PhDec: begin
        fin = 1'b1;
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  assign can_emit     = busy_q && (!out_valid_q || out_ready_i);
  assign item_ready_o = !busy_q || (can_emit && fin);
  assign take         = item_valid_i && item_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= 8'h00;
      last_q      <= 1'b0;
      decoded_q   <= 64'd0;
      reply_q     <= 4'd0;
      err_q       <= 1'b0;
      item_q      <= '0;
      data_q      <= 64'd0;
      phase_q     <= PhTms;
      idx_q       <= 3'd0;
    end else begin
      if (can_emit) begin
        out_valid_q <= 1'b1;
        out_byte_q  <= byte_d;
        last_q      <= fin;
        decoded_q   <= (phase_q == PhDec) ? data_q : 64'd0;
        reply_q     <= item_q.reply_bytes;
        err_q       <= item_q.error;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (take) begin
        busy_q  <= 1'b1;
        item_q  <= item_i;
        data_q  <= word_i;
        phase_q <= item_i.decode ? PhDec : PhTms;
        idx_q   <= 3'd0;
      end else begin
        if (can_emit) begin
          phase_q <= phase_d;
          idx_q   <= idx_d;
          data_q  <= data_d;
        end
        if (can_emit && fin) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign last_byte_o    = last_q;
  assign decoded_word_o = decoded_q;
  assign reply_bytes_o  = reply_q;
  assign error_o        = err_q;

  // empty requests never reach the sequencer
  a_no_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !item_q.decode |-> item_q.tms_len != 4'd0)
    else $error("empty request held in sequencer");

  a_data_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && phase_q == PhData |-> item_q.nbytes != 3'd0)
    else $error("data phase with no whole bytes");

  a_tms_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && phase_q == PhTms |-> idx_q <= tms_end)
    else $error("prologue index overrun");

  a_decode_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && decoded_word_o != 64'd0 |-> last_byte_o && out_byte_o == 8'h00)
    else $error("decoded word on an encode beat");

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the JTAG scan to MPSSE command encoder
// Drives scan requests and reply words through the input channel with random
// gaps, runs them through an independent encoder and reply repair model, and
// compares every output beat field by field, under random output stalls.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NumRandom   = 460;
  localparam int StallLimit  = 2000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 40;

  typedef struct packed {
    logic        mode;
    logic [3:0]  tms_count;
    logic [13:0] tms_bits;
    logic [6:0]  data_count;
    logic [63:0] data_bits;
    logic        capture;
    logic [63:0] reply_word;
    // hand-typed expectation, used only where typed is set
    logic        typed;
    logic [4:0]  exp_n;
    logic [3:0]  exp_reply;
    logic        exp_err;
    logic [63:0] exp_word;
  } scan_req_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_byte;
    logic [63:0] decoded_word;
    logic [3:0]  reply_bytes;
    logic        err;
  } cmd_beat_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        out_ready = 1'b0;
  scan_req_t   offered   = '0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic        last_byte_o;
  logic [63:0] decoded_word_o;
  logic [3:0]  reply_bytes_o;
  logic        error_o;

  // repair masks left by the latest capture scan
  logic [2:0]  rep_partial_bits = '0;
  logic [3:0]  rep_word_bytes   = '0;
  logic [63:0] rep_partial_mask = '0;
  logic [63:0] rep_lastbit_mask = '0;
  logic [63:0] rep_top_mask     = '0;

  cmd_beat_t   awaited_beats[$];
  int          err_count = 0;
  int          hold_len  = 0;
  bit          tx_fast   = 1'b0;
  bit          rx_fast   = 1'b0;

  scan_req_t dir_rows [25] = '{
    // decode straight after reset passes the word through
    '{1'b1, 4'd0, 14'h0000, 7'd0, 64'h0, 1'b0, 64'h0123_4567_89ab_cdef,
      1'b1, 5'd1, 4'd0, 1'b0, 64'h0123_4567_89ab_cdef},
    // empty request, capture without data leaves the masks alone
    '{1'b0, 4'd0, 14'h3fff, 7'd0, 64'hffff_ffff_ffff_ffff, 1'b1, 64'h0,
      1'b1, 5'd0, 4'd0, 1'b0, 64'h0},
    '{1'b0, 4'd1, 14'h0001, 7'd0, 64'h0, 1'b0, 64'h0, 1'b1, 5'd3, 4'd0, 1'b0, 64'h0},
    '{1'b0, 4'd7, 14'h007f, 7'd0, 64'h0, 1'b0, 64'h0, 1'b1, 5'd3, 4'd0, 1'b0, 64'h0},
    '{1'b0, 4'd8, 14'h00aa, 7'd0, 64'h0, 1'b0, 64'h0, 1'b1, 5'd6, 4'd0, 1'b0, 64'h0},
    '{1'b0, 4'd14, 14'h3fff, 7'd0, 64'h0, 1'b0, 64'h0, 1'b1, 5'd6, 4'd0, 1'b0, 64'h0},
    // prologue above 14 with no data is clamped
    '{1'b0, 4'd15, 14'h3fff, 7'd0, 64'h0, 1'b0, 64'h0, 1'b1, 5'd6, 4'd0, 1'b0, 64'h0},
    '{1'b0, 4'd12, 14'h1555, 7'd0, 64'h0, 1'b0, 64'h0, 1'b1, 5'd6, 4'd0, 1'b0, 64'h0},
    '{1'b0, 4'd0, 14'h0000, 7'd1, 64'h1, 1'b0, 64'h0, 1'b1, 5'd9, 4'd0, 1'b0, 64'h0},
    '{1'b0, 4'd0, 14'h0000, 7'd8, 64'hff, 1'b1, 64'h0, 1'b1, 5'd12, 4'd2, 1'b0, 64'h0},
    '{1'b1, 4'd0, 14'h0000, 7'd0, 64'h0, 1'b0, 64'hffff_ffff_ffff_ffff,
      1'b0, 5'd0, 4'd0, 1'b0, 64'h0},
    '{1'b0, 4'd3, 14'h0005, 7'd9, 64'h1ff, 1'b1, 64'h0, 1'b1, 5'd13, 4'd2, 1'b0, 64'h0},
    '{1'b1, 4'd0, 14'h0000, 7'd0, 64'h0, 1'b0, 64'h8000_0000_0000_01c3,
      1'b0, 5'd0, 4'd0, 1'b0, 64'h0},
    // full length capture, longest prologue with data, last-bit mask runs off the word
    '{1'b0, 4'd11, 14'h07ff, 7'd64, 64'hffff_ffff_ffff_ffff, 1'b1, 64'h0,
      1'b1, 5'd25, 4'd9, 1'b1, 64'h0},
    '{1'b1, 4'd0, 14'h0000, 7'd0, 64'h0, 1'b0, 64'hffff_ffff_ffff_ffff,
      1'b0, 5'd0, 4'd0, 1'b0, 64'h0},
    // over-long data and prologue both saturate
    '{1'b0, 4'd15, 14'h3fff, 7'd127, 64'h0, 1'b1, 64'h0, 1'b1, 5'd25, 4'd9, 1'b1, 64'h0},
    '{1'b1, 4'd0, 14'h0000, 7'd0, 64'h0, 1'b0, 64'h0, 1'b0, 5'd0, 4'd0, 1'b0, 64'h0},
    '{1'b0, 4'd0, 14'h0000, 7'd57, 64'h00ff_ffff_ffff_ffff, 1'b1, 64'h0,
      1'b1, 5'd19, 4'd8, 1'b1, 64'h0},
    '{1'b1, 4'd0, 14'h0000, 7'd0, 64'h0, 1'b0, 64'hc0ff_ee00_1234_5678,
      1'b0, 5'd0, 4'd0, 1'b0, 64'h0},
    '{1'b0, 4'd0, 14'h0000, 7'd56, 64'h0055_aa55_aa55_aa55, 1'b1, 64'h0,
      1'b1, 5'd21, 4'd8, 1'b0, 64'h0},
    '{1'b1, 4'd0, 14'h0000, 7'd0, 64'h0, 1'b0, 64'h7fff_ffff_ffff_ffff,
      1'b0, 5'd0, 4'd0, 1'b0, 64'h0},
    '{1'b0, 4'd0, 14'h0000, 7'd64, 64'ha5a5_5a5a_0f0f_f0f0, 1'b0, 64'h0,
      1'b1, 5'd22, 4'd0, 1'b0, 64'h0},
    '{1'b0, 4'd5, 14'h2a5a, 7'd33, 64'h1_2345_6789, 1'b1, 64'h0,
      1'b0, 5'd0, 4'd0, 1'b0, 64'h0},
    '{1'b1, 4'd0, 14'h0000, 7'd0, 64'h0, 1'b0, 64'hdead_beef_cafe_f00d,
      1'b0, 5'd0, 4'd0, 1'b0, 64'h0},
    // decode ignores the scan fields
    '{1'b1, 4'd15, 14'h3fff, 7'd127, 64'hffff_ffff_ffff_ffff, 1'b1,
      64'h5555_aaaa_5555_aaaa, 1'b0, 5'd0, 4'd0, 1'b0, 64'h0}
  };

  jtag_scan_mpsse_command_encoder_unit u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .mode_i         (offered.mode),
    .tms_count_i    (offered.tms_count),
    .tms_bits_i     (offered.tms_bits),
    .data_count_i   (offered.data_count),
    .data_bits_i    (offered.data_bits),
    .capture_i      (offered.capture),
    .reply_word_i   (offered.reply_word),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .out_byte_o     (out_byte_o),
    .last_byte_o    (last_byte_o),
    .decoded_word_o (decoded_word_o),
    .reply_bytes_o  (reply_bytes_o),
    .error_o        (error_o)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] repair_reply(input logic [63:0] raw);
    logic [63:0] hb;
    logic [63:0] top;
    logic [63:0] w;
    w  = raw;
    hb = raw & rep_lastbit_mask;
    // partial byte arrives MSB aligned, shift it down into place
    if (rep_partial_bits != 3'd0) begin
      top = rep_partial_mask & ((raw & rep_partial_mask) >> (8 - rep_partial_bits));
      w   = (raw & ~rep_partial_mask) | top;
    end
    w = w & (rep_top_mask - 64'd1);
    if (hb != 64'd0) w = w | rep_top_mask;
    return w;
  endfunction

  task automatic encode_request(input scan_req_t r, output int n);
    logic [7:0]  seq[$];
    logic [3:0]  tc;
    logic [14:0] tb;
    logic [6:0]  dc;
    logic [63:0] tdi;
    logic [5:0]  last_idx;
    logic [2:0]  nbytes;
    logic [2:0]  lbb;
    logic [3:0]  reply;
    logic        err;
    cmd_beat_t   b;
    tc    = r.tms_count;
    tb    = {1'b0, r.tms_bits};
    dc    = r.data_count;
    tdi   = r.data_bits;
    reply = '0;
    err   = 1'b0;
    if (r.mode) begin
      b = '{8'h00, 1'b1, repair_reply(r.reply_word), 4'd0, 1'b0};
      awaited_beats.push_back(b);
      n = 1;
    end else begin
      if (dc > 7'(jsme_pkg::MaxScanBitsDef)) dc = 7'(jsme_pkg::MaxScanBitsDef);
      if (dc != 7'd0) begin
        if (tc > jsme_pkg::TmsMaxData) tc = jsme_pkg::TmsMaxData;
      end else if (tc > jsme_pkg::TmsMaxIdle) begin
        tc = jsme_pkg::TmsMaxIdle;
      end
      tb = tb & ((15'd1 << tc) - 15'd1);
      // data scans append the 1,0,0 walk to shift-dr
      if (dc != 7'd0) begin
        tb = tb | (15'd1 << tc);
        tc = tc + 4'd3;
      end
      if (tc != 4'd0) begin
        seq.push_back(jsme_pkg::CmdTms);
        if (tc < 4'd8) begin
          seq.push_back(8'(tc - 4'd1));
          seq.push_back(tb[7:0]);
        end else begin
          seq.push_back(8'd6);
          seq.push_back({1'b0, tb[6:0]});
          seq.push_back(jsme_pkg::CmdTms);
          seq.push_back(8'(tc - 4'd8));
          seq.push_back(tb[14:7]);
        end
      end
      if (dc != 7'd0) begin
        last_idx = 6'(dc - 7'd1);
        nbytes   = last_idx[5:3];
        lbb      = last_idx[2:0];
        if (r.capture) begin
          rep_partial_bits = lbb;
          rep_lastbit_mask = '0;
          rep_partial_mask = '0;
          rep_word_bytes   = {1'b0, nbytes} + ((lbb != 3'd0) ? 4'd1 : 4'd0);
        end
        if (nbytes != 3'd0) begin
          seq.push_back(r.capture ? jsme_pkg::CmdBytesRd : jsme_pkg::CmdBytes);
          seq.push_back(8'(nbytes - 3'd1));
          seq.push_back(8'h00);
          for (int i = 0; i < int'(nbytes); i++) begin
            seq.push_back(tdi[7:0]);
            tdi = tdi >> 8;
          end
        end
        if (lbb != 3'd0) begin
          seq.push_back(r.capture ? jsme_pkg::CmdBitsRd : jsme_pkg::CmdBits);
          seq.push_back(8'(lbb - 3'd1));
          seq.push_back(tdi[7:0]);
          tdi = tdi >> lbb;
          if (r.capture) rep_partial_mask = 64'hff << ((rep_word_bytes - 4'd1) * 8);
        end
        // final bit goes out with tms high
        seq.push_back(r.capture ? jsme_pkg::CmdTmsRd : jsme_pkg::CmdTms);
        seq.push_back(8'h01);
        seq.push_back({tdi[0], 7'h03});
        if (r.capture) begin
          rep_lastbit_mask = (rep_word_bytes < 4'd8) ? (64'h40 << (rep_word_bytes * 8)) : '0;
          rep_word_bytes   = rep_word_bytes + 4'd1;
          rep_top_mask     = 64'd1 << (dc - 7'd1);
          reply            = rep_word_bytes;
          err              = dc > jsme_pkg::ErrLimit;
        end
        seq.push_back(jsme_pkg::CmdTms);
        seq.push_back(8'h00);
        seq.push_back(8'h00);
      end
      foreach (seq[i]) begin
        b = '{seq[i], (i == seq.size() - 1), 64'h0, reply, err};
        awaited_beats.push_back(b);
      end
      n = seq.size();
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic scan_req_t random_request();
    scan_req_t r;
    r            = '0;
    r.tms_count  = 4'($urandom_range(0, 15));
    r.tms_bits   = 14'($urandom);
    // mostly in range, now and then an over-long count
    r.data_count = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(0, 64));
    r.data_bits  = rand64();
    r.capture    = 1'($urandom);
    r.reply_word = rand64();
    return r;
  endfunction

  task automatic send_request(input scan_req_t r);
    int gap;
    gap = (tx_fast || hold_len != 0) ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    offered  <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
  endtask

  always @(posedge clk) begin : scoreboard
    cmd_beat_t e;
    int        n;
    if (out_valid_o && out_ready) begin
      if (awaited_beats.size() == 0) begin
        $error("beat with nothing pending: out_byte %0h", out_byte_o);
        err_count++;
      end else begin
        e = awaited_beats.pop_front();
        if (out_byte_o !== e.out_byte) begin
          $error("out_byte: expected %0h, got %0h", e.out_byte, out_byte_o);
          err_count++;
        end
        if (last_byte_o !== e.last_byte) begin
          $error("last_byte: expected %0b, got %0b", e.last_byte, last_byte_o);
          err_count++;
        end
        if (decoded_word_o !== e.decoded_word) begin
          $error("decoded_word: expected %0h, got %0h", e.decoded_word, decoded_word_o);
          err_count++;
        end
        if (reply_bytes_o !== e.reply_bytes) begin
          $error("reply_bytes: expected %0d, got %0d", e.reply_bytes, reply_bytes_o);
          err_count++;
        end
        if (error_o !== e.err) begin
          $error("error: expected %0b, got %0b", e.err, error_o);
          err_count++;
        end
      end
    end
    if (in_valid && in_ready_o) begin
      encode_request(offered, n);
      // hand-typed rows take their flags and word from the row itself
      if (offered.typed) begin
        if (n != int'(offered.exp_n)) begin
          $error("beat count: expected %0d, got %0d", offered.exp_n, n);
          err_count++;
        end
        for (int i = awaited_beats.size() - n; i < awaited_beats.size(); i++) begin
          e             = awaited_beats[i];
          e.reply_bytes = offered.exp_reply;
          e.err         = offered.exp_err;
          if (offered.mode) e.decoded_word = offered.exp_word;
          awaited_beats[i] = e;
        end
      end
    end
  end

  initial begin : sink
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) rx_fast = !rx_fast;
      // long hold-off so the encoder backs up into the input channel
      if (hold_len != 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      stall = rx_fast ? 0 : $urandom_range(0, 8);
      repeat (stall) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid_o) @(posedge clk);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle = 0;
      else idle++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    scan_req_t r;
    int        sent;
    int        kind;
    bit        hold_done;
    bit        pause_done;
    sent       = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_request(dir_rows[i]);

    while (sent < NumRandom) begin
      if ($urandom_range(0, 39) == 0) tx_fast = !tx_fast;
      if (!hold_done && sent >= 120) begin
        hold_len  = HoldCycles;
        hold_done = 1'b1;
      end
      // let the output side run completely dry once
      if (!pause_done && sent >= 300) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_beats.size() != 0) @(posedge clk);
        pause_done = 1'b1;
      end
      kind = $urandom_range(0, 9);
      r    = random_request();
      if (kind < 4) begin
        // capture scan then the reply it produces
        r.capture    = 1'b1;
        r.data_count = 7'($urandom_range(1, 64));
        send_request(r);
        r      = random_request();
        r.mode = 1'b1;
        case ($urandom_range(0, 3))
          0:       r.reply_word = '1;
          1:       r.reply_word = '0;
          default: ;
        endcase
        send_request(r);
        sent += 2;
      end else if (kind < 7) begin
        send_request(r);
        sent++;
      end else if (kind < 9) begin
        r.mode = 1'b1;
        send_request(r);
        sent++;
      end else begin
        // prologue only, or nothing at all
        r.data_count = '0;
        if ($urandom_range(0, 3) == 0) r.tms_count = '0;
        send_request(r);
        sent++;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0 && awaited_beats.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
sv/jsme_pkg.sv
sv/jsme_emit.sv
sv/jtag_scan_mpsse_command_encoder_unit.sv
sim/tb_top.sv
